// ----- design/sfla_pkg.sv -----
`default_nettype none
package sfla_pkg;
    localparam int ArenaBytes    = 65536;
    localparam int NumClasses    = 16;
    localparam int MaxSmallBytes = 128;
    localparam int GranuleBytes  = 8;
    localparam int RefillBlocks  = 20;

    localparam int ADDR_W = 16;
    localparam int SIZE_W = 12;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TOO_LARGE = 2'd1;
    localparam logic [1:0] STATUS_OOM       = 2'd2;

    localparam logic ACTION_ALLOC = 1'b0;
    localparam logic ACTION_FREE  = 1'b1;

    // result of the iterative divider
    typedef struct packed {
        logic        done;
        logic [16:0] quotient;
    } sfla_div_rsp_t;
endpackage
`default_nettype wire

// ----- design/segregated_free_list_allocator.sv -----
`default_nettype none
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_ready   | action, request_bytes, block_address
// out     | output    | out_valid/out_ready | result_address, status
//
// One transaction at a time; in_ready is low from acceptance until the result is taken.
// A free or a rejected request goes from decode straight to the result; a pop also
// reads and writes back the link store. Refill: the check and the chunk divide (one
// quotient bit per cycle in the divider), then the blocks are threaded (up to 19, one
// link-store write per cycle) and the chunk is closed. Arena exhausted: a borrow scan
// over up to NUM_CLASSES classes.
// Reset clears lists and chunk state at once; the link store needs no clearing.
// The result holds in its register while out_ready is low.
module segregated_free_list_allocator #(
    parameter int ARENA_BYTES     = sfla_pkg::ArenaBytes,
    parameter int NUM_CLASSES     = sfla_pkg::NumClasses,
    parameter int MAX_SMALL_BYTES = sfla_pkg::MaxSmallBytes,
    parameter int GRANULE_BYTES   = sfla_pkg::GranuleBytes,
    parameter int REFILL_BLOCKS   = sfla_pkg::RefillBlocks
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire logic        action,
    input  wire logic [11:0] request_bytes,
    input  wire logic [15:0] block_address,
    output      logic        out_valid,
    input  wire logic        out_ready,
    output      logic [15:0] result_address,
    output      logic [1:0]  status
);
    localparam int GSH   = $clog2(GRANULE_BYTES);
    localparam int DEPTH = ARENA_BYTES / GRANULE_BYTES;
    localparam int LW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CLW   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int NW    = $clog2(REFILL_BLOCKS + 1);
    localparam logic [16:0] ARENA17 = 17'(ARENA_BYTES);
    localparam logic [16:0] GMASK   = 17'(GRANULE_BYTES - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_POP_RD, S_POP_WR, S_CHECK, S_DIV, S_THREAD,
        S_LEFTOVER, S_WANT, S_SCAN, S_SCAN_RD, S_SCAN_WR, S_OUT
    } state_t;

    state_t      state_reg;
    logic [16:0] head_reg [NUM_CLASSES];
    logic [16:0] cstart_reg, cend_reg, taken_reg;
    logic [12:0] bytes_reg;
    logic [CLW-1:0] cls_reg, scan_reg;
    logic        too_big_reg, act_reg, attempt_reg;
    logic [15:0] baddr_reg, addr_reg;
    logic [1:0]  status_reg;
    logic [NW-1:0] n_reg, i_reg;
    logic [16:0] base_reg;

    logic        wr_en;
    logic [LW-1:0] wr_addr, rd_addr;
    logic [16:0] wr_data, rd_data;
    logic        div_start;
    sfla_pkg::sfla_div_rsp_t div_rsp;

    logic [12:0] req_eff, bytes_c;
    logic [16:0] left;
    logic [16:0] want;
    logic [16:0] tk_rnd;
    logic [16:0] cur_head;

    sfla_div #(.W(17)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (left),
        .divisor  ({4'd0, bytes_reg}),
        .rsp      (div_rsp)
    );

    sfla_link_mem #(.DEPTH(DEPTH), .DW(17)) u_link (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        req_eff  = (request_bytes == 12'd0) ? 13'(GRANULE_BYTES) : {1'b0, request_bytes};
        bytes_c  = (req_eff + 13'(GRANULE_BYTES - 1)) & ~13'(GRANULE_BYTES - 1);
        left     = cend_reg - cstart_reg;
        tk_rnd   = ({4'd0, taken_reg[16:4]} + GMASK) & ~GMASK;
        want     = 17'(2 * REFILL_BLOCKS) * {4'd0, bytes_reg} + tk_rnd;
        cur_head = head_reg[(state_reg == S_SCAN || state_reg == S_SCAN_RD
                             || state_reg == S_SCAN_WR) ? scan_reg : cls_reg];
        in_ready = (state_reg == S_IDLE);
        div_start = (state_reg == S_CHECK) && (left >= {4'd0, bytes_reg});
        rd_addr  = LW'(cur_head[15:GSH]);
        wr_en    = 1'b0;
        wr_addr  = LW'(baddr_reg[15:GSH]);
        wr_data  = head_reg[cls_reg];
        unique case (state_reg)
            S_DECODE:
            begin
                wr_en = act_reg == sfla_pkg::ACTION_FREE && !too_big_reg
                        && {1'b0, baddr_reg} < ARENA17;
            end
            S_THREAD:
            begin
                wr_en   = i_reg < n_reg;
                wr_addr = LW'(base_reg[15:GSH]);
            end
            S_LEFTOVER:
            begin
                wr_en   = left >= 17'(GRANULE_BYTES)
                          && (left >> GSH) <= 17'(NUM_CLASSES);
                wr_addr = LW'(cstart_reg[15:GSH]);
                wr_data = head_reg[CLW'((left >> GSH) - 17'd1)];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            for (int k = 0; k < NUM_CLASSES; k++)
            begin
                head_reg[k] <= '0;
            end
            cstart_reg <= '0;
            cend_reg   <= '0;
            taken_reg  <= '0;
            out_valid  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        act_reg     <= action;
                        baddr_reg   <= block_address;
                        bytes_reg   <= bytes_c;
                        cls_reg     <= CLW'((bytes_c >> GSH) - 13'd1);
                        too_big_reg <= req_eff > 13'(MAX_SMALL_BYTES)
                                       || (bytes_c >> GSH) > 13'(NUM_CLASSES);
                        addr_reg    <= '0;
                        status_reg  <= sfla_pkg::STATUS_OK;
                        attempt_reg <= 1'b0;
                        state_reg   <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    if (too_big_reg)
                    begin
                        status_reg <= sfla_pkg::STATUS_TOO_LARGE;
                        state_reg  <= S_OUT;
                    end
                    else if (act_reg == sfla_pkg::ACTION_FREE)
                    begin
                        if (wr_en)
                        begin
                            head_reg[cls_reg] <= {1'b1, baddr_reg};
                        end
                        state_reg <= S_OUT;
                    end
                    else if (head_reg[cls_reg][16])
                    begin
                        state_reg <= S_POP_RD;
                    end
                    else
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_POP_RD:
                begin
                    state_reg <= S_POP_WR;
                end
                S_POP_WR:
                begin
                    addr_reg          <= head_reg[cls_reg][15:0];
                    head_reg[cls_reg] <= rd_data;
                    state_reg         <= S_OUT;
                end
                S_CHECK:
                begin
                    state_reg <= (left >= {4'd0, bytes_reg}) ? S_DIV : S_LEFTOVER;
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        n_reg    <= (div_rsp.quotient > 17'(REFILL_BLOCKS))
                                    ? NW'(REFILL_BLOCKS) : NW'(div_rsp.quotient);
                        i_reg    <= NW'(1);
                        addr_reg <= cstart_reg[15:0];
                        base_reg <= cstart_reg + {4'd0, bytes_reg};
                        state_reg <= S_THREAD;
                    end
                end
                S_THREAD:
                begin
                    if (wr_en)
                    begin
                        head_reg[cls_reg] <= {1'b1, base_reg[15:0]};
                        base_reg <= base_reg + {4'd0, bytes_reg};
                        i_reg    <= i_reg + 1'b1;
                    end
                    else
                    begin
                        // base already sits one block past the last pushed
                        cstart_reg <= base_reg;
                        state_reg  <= S_OUT;
                    end
                end
                S_LEFTOVER:
                begin
                    if (wr_en)
                    begin
                        head_reg[CLW'((left >> GSH) - 17'd1)] <= {1'b1, cstart_reg[15:0]};
                    end
                    cstart_reg <= cend_reg;
                    state_reg  <= S_WANT;
                end
                S_WANT:
                begin
                    if (!attempt_reg && want <= ARENA17 - taken_reg)
                    begin
                        cstart_reg  <= taken_reg;
                        cend_reg    <= taken_reg + want;
                        taken_reg   <= taken_reg + want;
                        attempt_reg <= 1'b1;
                        state_reg   <= S_CHECK;
                    end
                    else if (!attempt_reg)
                    begin
                        scan_reg  <= cls_reg;
                        state_reg <= S_SCAN;
                    end
                    else
                    begin
                        status_reg <= sfla_pkg::STATUS_OOM;
                        state_reg  <= S_OUT;
                    end
                end
                S_SCAN:
                begin
                    if (cur_head[16])
                    begin
                        state_reg <= S_SCAN_RD;
                    end
                    else if (32'(scan_reg) == NUM_CLASSES - 1)
                    begin
                        status_reg <= sfla_pkg::STATUS_OOM;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_WR;
                end
                S_SCAN_WR:
                begin
                    addr_reg           <= cur_head[15:0];
                    head_reg[scan_reg] <= rd_data;
                    state_reg          <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid)
                    begin
                        out_valid <= 1'b1;
                    end
                    else if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_address = (status_reg == sfla_pkg::STATUS_OK) ? addr_reg : 16'd0;
    assign status         = status_reg;

    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while result pending");
    a_taken_mono: assert property (@(posedge clk) disable iff (!rst_n)
        taken_reg >= $past(taken_reg))
        else $error("arena bump pointer went back");
    a_chunk_order: assert property (@(posedge clk) disable iff (!rst_n)
        cstart_reg <= cend_reg && cend_reg <= taken_reg)
        else $error("chunk bounds out of order");
    a_oom_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != sfla_pkg::STATUS_OK |-> result_address == 16'd0)
        else $error("address on failed request");
endmodule
`default_nettype wire

// ----- design/sfla_div.sv -----
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module sfla_div #(
    parameter int W = 17
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [W-1:0]           dividend,
    input  wire logic [W-1:0]           divisor,
    output sfla_pkg::sfla_div_rsp_t     rsp
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quot_reg, quot_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quot_reg[W-1]} - {1'b0, dvs_reg};
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                rem_next  = trial[W-1:0];
                quot_next = {quot_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = {rem_reg[W-2:0], quot_reg[W-1]};
                quot_next = {quot_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;
endmodule
`default_nettype wire

// ----- design/sfla_link_mem.sv -----
`default_nettype none
// Next-link store: one write port, one registered read port.
module sfla_link_mem #(
    parameter int DEPTH = 8192,
    parameter int DW    = 17
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DW-1:0]            wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [DW-1:0]            rd_data
);
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire
